// ----- sv/vm_region_fault_resolver_macros.svh -----
// Assertion macros shared by the region resolver RTL.
`ifndef VM_REGION_FAULT_RESOLVER_MACROS_SVH
`define VM_REGION_FAULT_RESOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define VRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/vrf_pkg.sv -----
// Package: constants, codes and types of the region fault resolver.
package vrf_pkg;
    localparam int MAX_REGIONS  = 16;
    localparam int SHARED_SLOTS = 8;
    localparam int OBJ_PAGE_LIMIT = 16;
    localparam int PAGE_SHIFT   = 12;
    localparam int RIDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int ENT_W  = 32 + 32 + 7 + 3;

    localparam logic [31:0] FLOOR_RST = 32'h4000_0000;
    localparam logic [31:0] CEIL_RST  = 32'hC000_0000;

    typedef enum logic [2:0] {
        K_MAP = 3'd0, K_UNMAP = 3'd1, K_FAULT = 3'd2,
        K_CREATE = 3'd3, K_MAPSH = 3'd4, K_CLEAR = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        A_NONE = 3'd0, A_POPULATE = 3'd1, A_FREE = 3'd2,
        A_SHARED = 3'd3, A_COPY = 3'd4, A_ZERO = 3'd5
    } t_action;

    localparam int FB_WRITE = 1;
    localparam int FB_USER = 2;
    localparam int FB_DEMAND = 3;
    localparam int FB_GUARD = 4;
    localparam int FB_COW = 5;
    localparam int FB_SHARED = 6;

    // Attributes of a shared mapping: read, write, user, shared
    localparam logic [6:0] SH_ATTR = 7'h47;

    localparam logic CFG_FLOOR = 1'b0;
    localparam logic CFG_CEIL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_MOVE, S_WR, S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [31:0] length;
        logic [6:0]  region_flags_in;
        logic [2:0]  shared_slot;
        logic [4:0]  page_count;
        logic        frame_ok;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [2:0]  action;
        logic [2:0]  mmu_bits;
        logic [31:0] base_out;
        logic [31:0] end_out;
        logic [2:0]  slot_out;
        logic [3:0]  pg_offset;
    } t_rsp;

    function automatic logic [2:0] mmu_of(input logic [6:0] a);
        mmu_of = {a[FB_USER], a[FB_WRITE], 1'b1};
    endfunction
endpackage

// ----- sv/vrf_stream_if.sv -----
// Valid/ready stream interface carrying one payload.
interface vrf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/vrf_ram.sv -----
// Generic single-port RAM with registered read.
module vrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

// ----- sv/vm_region_fault_resolver.sv -----
// Region fault resolver: one request in flight, region table held in one RAM.
// Map, create, map shared, clear: decided in the check state, then the output state raises the result.
// Unmap and fault walk the table with a read and a compare state per region entry visited;
// unmap adds a write state to move the last entry into the hole. The next input
// transfer is taken after the result transfer.
// Synchronous active-low reset empties the table and frees all shared slots.
`include "vm_region_fault_resolver_macros.svh"
module vm_region_fault_resolver (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic [31:0] i_cfg_data,
    vrf_stream_if.sink   s_in,
    vrf_stream_if.source m_out
);
    import vrf_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp, n_rsp;
    logic   r_ovalid, n_ovalid;
    logic [31:0] r_floor, r_ceil;
    logic [CNT_W-1:0] r_live, n_live;
    logic [RIDX_W-1:0] r_idx, n_idx;
    logic [RIDX_W-1:0] r_hit, n_hit;
    logic [4:0] r_pages [SHARED_SLOTS];
    logic [ENT_W-1:0] r_ent, n_ent;
    logic ram_we;
    logic [RIDX_W-1:0] ram_addr;
    logic [ENT_W-1:0] ram_wdata, ram_rdata;
    logic pg_we;
    logic [2:0] pg_idx;
    logic [4:0] pg_val;

    vrf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_REGIONS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    // Decode the held request
    logic [31:0] base, endv, sh_end;
    logic [31:0] e_base, e_lim;
    logic [6:0]  e_attr;
    logic [2:0]  e_slot;
    logic [31:0] pdiff;
    logic [2:0]  free_slot;
    logic        free_any;
    logic [6:0]  na;

    always_comb begin
        base = r_req.address & ~((32'd1 << PAGE_SHIFT) - 32'd1);
        endv = (r_req.address + r_req.length + ((32'd1 << PAGE_SHIFT) - 32'd1))
             & ~((32'd1 << PAGE_SHIFT) - 32'd1);
        sh_end = r_req.address + (32'(r_pages[r_req.shared_slot]) << PAGE_SHIFT);
        {e_base, e_lim, e_attr, e_slot} = r_ent;
        pdiff = (base - e_base) >> PAGE_SHIFT;
        na = e_attr;
        na[FB_COW] = 1'b0;
        na[FB_WRITE] = 1'b1;
        free_any = 1'b0;
        free_slot = '0;
        for (int k = SHARED_SLOTS - 1; k >= 0; k--) begin
            if (r_pages[k] == 5'd0) begin
                free_any = 1'b1;
                free_slot = 3'(k);
            end
        end
    end

    // Hold the transfer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_live <= '0;
            r_floor <= FLOOR_RST;
            r_ceil <= CEIL_RST;
            for (int k = 0; k < SHARED_SLOTS; k++) r_pages[k] <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_live <= n_live;
            if (i_cfg_we && i_cfg_index == CFG_FLOOR) r_floor <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_CEIL) r_ceil <= i_cfg_data;
            if (pg_we) r_pages[pg_idx] <= pg_val;
        end
        if (s_in.valid && s_in.ready) r_req <= s_in.data;
        r_rsp <= n_rsp;
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_ent <= n_ent;
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_rsp;

    // Sequence one request
    always_comb begin
        n_state = r_state;
        n_rsp = r_rsp;
        n_ovalid = r_ovalid && !m_out.ready;
        n_live = r_live;
        n_idx = r_idx;
        n_hit = r_hit;
        n_ent = r_ent;
        ram_we = 1'b0;
        ram_addr = r_idx;
        ram_wdata = r_ent;
        pg_we = 1'b0;
        pg_idx = r_req.shared_slot;
        pg_val = r_req.page_count;
        unique case (r_state)
            S_IDLE: begin
                if (s_in.valid && s_in.ready) begin
                    n_state = S_CHK;
                    n_idx = '0;
                    n_rsp = '0;
                end
            end
            S_CHK: begin
                // decide or start walk
                n_state = S_OUT;
                n_rsp = '0;
                case (r_req.kind) inside
                    K_MAP: begin
                        if (r_req.length != 0 && r_live < CNT_W'(MAX_REGIONS) &&
                            !(r_req.region_flags_in[FB_USER] &&
                              (base < r_floor || endv > r_ceil))) begin
                            ram_we = 1'b1;
                            ram_addr = r_live[RIDX_W-1:0];
                            ram_wdata = {base, endv, r_req.region_flags_in, 3'd0};
                            n_live = r_live + 1'b1;
                            if (r_req.region_flags_in[FB_DEMAND] ||
                                r_req.region_flags_in[FB_GUARD]) begin
                                n_rsp.ok = 1'b1;
                                n_rsp.base_out = base;
                                n_rsp.end_out = endv;
                            end else if (r_req.frame_ok) begin
                                n_rsp.ok = 1'b1;
                                n_rsp.action = A_POPULATE;
                                n_rsp.mmu_bits = mmu_of(r_req.region_flags_in);
                                n_rsp.base_out = base;
                                n_rsp.end_out = endv;
                            end
                        end
                    end
                    K_UNMAP, K_FAULT: begin
                        if ((r_req.kind == K_FAULT || r_req.length != 0) &&
                            CNT_W'(r_idx) < r_live) begin
                            ram_addr = r_idx;
                            n_state = S_RD;
                        end
                    end
                    K_CREATE: begin
                        if (r_req.page_count != 0 &&
                            r_req.page_count <= 5'(OBJ_PAGE_LIMIT) &&
                            free_any && r_req.frame_ok) begin
                            pg_we = 1'b1;
                            pg_idx = free_slot;
                            n_rsp.ok = 1'b1;
                            n_rsp.slot_out = free_slot;
                        end
                    end
                    K_MAPSH: begin
                        if (r_pages[r_req.shared_slot] != 0 &&
                            r_live < CNT_W'(MAX_REGIONS)) begin
                            ram_we = 1'b1;
                            ram_addr = r_live[RIDX_W-1:0];
                            ram_wdata = {r_req.address, sh_end, SH_ATTR,
                                         r_req.shared_slot};
                            n_live = r_live + 1'b1;
                            n_rsp.ok = 1'b1;
                            n_rsp.action = A_SHARED;
                            n_rsp.mmu_bits = mmu_of(SH_ATTR);
                            n_rsp.base_out = r_req.address;
                            n_rsp.end_out = sh_end;
                            n_rsp.slot_out = r_req.shared_slot;
                        end
                    end
                    K_CLEAR: begin
                        n_live = '0;
                        n_rsp.ok = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                // capture the entry read last cycle
                n_ent = ram_rdata;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                // compare the captured entry
                n_state = S_OUT;
                if (r_req.kind == K_UNMAP) begin
                    if (e_base == base && e_lim == endv) begin
                        n_rsp.ok = 1'b1;
                        n_rsp.action = (e_attr[FB_GUARD] || e_attr[FB_DEMAND] ||
                                        e_attr[FB_SHARED]) ? A_NONE : A_FREE;
                        n_rsp.base_out = base;
                        n_rsp.end_out = endv;
                        n_hit = r_idx;
                        ram_addr = RIDX_W'(r_live - 1'b1);
                        n_state = S_WR;
                    end
                end else if (!(base < e_base || base >= e_lim) &&
                             (e_attr[FB_GUARD] || e_attr[FB_SHARED] ||
                              e_attr[FB_COW] || e_attr[FB_DEMAND])) begin
                    if (e_attr[FB_GUARD]) begin
                        n_rsp = '0;
                    end else if (e_attr[FB_SHARED]) begin
                        if (pdiff < 32'(r_pages[e_slot])) begin
                            n_rsp.ok = 1'b1;
                            n_rsp.action = A_SHARED;
                            n_rsp.mmu_bits = mmu_of(e_attr);
                            n_rsp.base_out = base;
                            n_rsp.slot_out = e_slot;
                            n_rsp.pg_offset = pdiff[3:0];
                        end
                    end else if (r_req.frame_ok) begin
                        n_rsp.ok = 1'b1;
                        n_rsp.base_out = base;
                        if (e_attr[FB_COW]) begin
                            n_rsp.action = A_COPY;
                            n_rsp.mmu_bits = mmu_of(na);
                            ram_we = 1'b1;
                            ram_wdata = {e_base, e_lim, na, e_slot};
                        end else begin
                            n_rsp.action = A_ZERO;
                            n_rsp.mmu_bits = mmu_of(e_attr);
                        end
                    end
                end
                if (n_state == S_OUT && !n_rsp.ok && r_idx != RIDX_W'(MAX_REGIONS - 1)
                    && CNT_W'(r_idx) + 1'b1 < r_live &&
                    !(r_req.kind == K_FAULT && !(base < e_base || base >= e_lim) &&
                      (e_attr[FB_GUARD] || e_attr[FB_SHARED] ||
                       e_attr[FB_COW] || e_attr[FB_DEMAND]))) begin
                    n_idx = r_idx + 1'b1;
                    ram_addr = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_WR: begin
                // move the last entry into the hole
                ram_we = 1'b1;
                ram_addr = r_hit;
                ram_wdata = ram_rdata;
                n_live = r_live - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `VRF_ASSERT_IMP(a_live_bound, i_clk, i_rst_n, 1'b1, r_live <= CNT_W'(MAX_REGIONS))
    `VRF_ASSERT_NXT(a_out_follows, i_clk, i_rst_n, r_state == S_OUT, r_ovalid)
    `VRF_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_in.ready)
    `VRF_ASSERT_NXT(a_fail_zero, i_clk, i_rst_n, r_ovalid && !r_rsp.ok && !m_out.ready,
                    r_rsp == '0)
endmodule

// ----- sim/vm_region_fault_resolver_tb.sv -----
// Testbench for the region fault resolver: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module vm_region_fault_resolver_tb;
    import vrf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = CFG_FLOOR;
    logic [31:0] i_cfg_data = '0;

    vrf_stream_if #(.T(t_req)) req_if ();
    vrf_stream_if #(.T(t_rsp)) rsp_if ();

    vm_region_fault_resolver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_in(req_if.sink), .m_out(rsp_if.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic [31:0] floor_q, ceil_q;
    logic [31:0] tbl_base [MAX_REGIONS];
    logic [31:0] tbl_limit [MAX_REGIONS];
    logic [6:0]  tbl_attr [MAX_REGIONS];
    logic [2:0]  tbl_slot [MAX_REGIONS];
    int          live_cnt;
    logic [4:0]  obj_pages [SHARED_SLOTS];

    t_req req_pending [$];
    t_rsp rsp_expected [$];
    int   mismatches = 0;
    int   idle_pct = 33;
    bit   drain_hold = 1'b0;

    localparam logic [31:0] PG = 32'd1 << PAGE_SHIFT;

    function automatic t_rsp mk(logic ok, t_action act, logic [2:0] mmu, logic [31:0] b,
                                logic [31:0] e, logic [2:0] s, logic [3:0] p);
        t_rsp r;
        r.ok = ok; r.action = act; r.mmu_bits = mmu; r.base_out = b;
        r.end_out = e; r.slot_out = s; r.pg_offset = p;
        return r;
    endfunction

    function automatic logic [2:0] page_bits(logic [6:0] a);
        return {a[FB_USER], a[FB_WRITE], 1'b1};
    endfunction

    // Compute the resolver outcome and update the table copy
    function automatic t_rsp resolve(t_req q);
        t_rsp nil;
        logic [31:0] base, e, pi;
        logic [6:0] a, na;
        int last;
        nil = '0;
        base = q.address & ~(PG - 1);
        e = (q.address + q.length + PG - 1) & ~(PG - 1);
        case (q.kind)
            K_MAP: begin
                if (q.length == 0 || live_cnt >= MAX_REGIONS) return nil;
                if (q.region_flags_in[FB_USER] && (base < floor_q || e > ceil_q)) return nil;
                tbl_base[live_cnt] = base; tbl_limit[live_cnt] = e;
                tbl_attr[live_cnt] = q.region_flags_in; tbl_slot[live_cnt] = 0;
                live_cnt++;
                if (q.region_flags_in[FB_DEMAND] || q.region_flags_in[FB_GUARD])
                    return mk(1, A_NONE, 0, base, e, 0, 0);
                if (!q.frame_ok) return nil;
                return mk(1, A_POPULATE, page_bits(q.region_flags_in), base, e, 0, 0);
            end
            K_UNMAP: begin
                if (q.length == 0) return nil;
                for (int i = 0; i < live_cnt; i++) begin
                    if (tbl_base[i] == base && tbl_limit[i] == e) begin
                        a = tbl_attr[i];
                        last = live_cnt - 1;
                        tbl_base[i] = tbl_base[last]; tbl_limit[i] = tbl_limit[last];
                        tbl_attr[i] = tbl_attr[last]; tbl_slot[i] = tbl_slot[last];
                        live_cnt = last;
                        return mk(1, (a[FB_GUARD] || a[FB_DEMAND] || a[FB_SHARED]) ?
                                  A_NONE : A_FREE, 0, base, e, 0, 0);
                    end
                end
                return nil;
            end
            K_FAULT: begin
                for (int i = 0; i < live_cnt; i++) begin
                    a = tbl_attr[i];
                    if (base < tbl_base[i] || base >= tbl_limit[i]) continue;
                    if (a[FB_GUARD]) return nil;
                    if (a[FB_SHARED]) begin
                        pi = (base - tbl_base[i]) >> PAGE_SHIFT;
                        if (pi >= obj_pages[tbl_slot[i]]) return nil;
                        return mk(1, A_SHARED, page_bits(a), base, 0, tbl_slot[i], pi[3:0]);
                    end
                    if (a[FB_COW]) begin
                        if (!q.frame_ok) return nil;
                        na = a; na[FB_COW] = 1'b0; na[FB_WRITE] = 1'b1;
                        tbl_attr[i] = na;
                        return mk(1, A_COPY, page_bits(na), base, 0, 0, 0);
                    end
                    if (a[FB_DEMAND]) begin
                        if (!q.frame_ok) return nil;
                        return mk(1, A_ZERO, page_bits(a), base, 0, 0, 0);
                    end
                end
                return nil;
            end
            K_CREATE: begin
                if (q.page_count == 0 || q.page_count > OBJ_PAGE_LIMIT) return nil;
                for (int i = 0; i < SHARED_SLOTS; i++) begin
                    if (obj_pages[i] == 0) begin
                        if (!q.frame_ok) return nil;
                        obj_pages[i] = q.page_count;
                        return mk(1, A_NONE, 0, 0, 0, i[2:0], 0);
                    end
                end
                return nil;
            end
            K_MAPSH: begin
                if (obj_pages[q.shared_slot] == 0 || live_cnt >= MAX_REGIONS) return nil;
                a = SH_ATTR;
                e = q.address + (32'(obj_pages[q.shared_slot]) << PAGE_SHIFT);
                tbl_base[live_cnt] = q.address; tbl_limit[live_cnt] = e;
                tbl_attr[live_cnt] = a; tbl_slot[live_cnt] = q.shared_slot;
                live_cnt++;
                return mk(1, A_SHARED, page_bits(a), q.address, e, q.shared_slot, 0);
            end
            K_CLEAR: begin
                live_cnt = 0;
                return mk(1, A_NONE, 0, 0, 0, 0, 0);
            end
            default: return nil;
        endcase
    endfunction

    // Driver: present queued requests, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                rsp_expected.push_back(resolve(req_if.data));
                void'(req_pending.pop_front());
            end
            if (req_pending.size() != 0 && !drain_hold &&
                $urandom_range(99) >= idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.data <= req_pending[0];
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp_if.data);
            end else begin
                exp_r = rsp_expected.pop_front();
                if (exp_r !== rsp_if.data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, rsp_if.data);
                end
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Shadow copy of the last map addresses, to aim faults and unmaps at live regions
    logic [31:0] recent_base [$];
    function automatic int live_cnt_hint();
        return recent_base.size();
    endfunction
    function automatic logic [31:0] hint_base();
        return recent_base[$urandom_range(recent_base.size() - 1)];
    endfunction

    function automatic t_req rand_req();
        t_req q;
        logic [31:0] pick;
        q.kind = t_kind'($urandom_range(99) < 3 ? $urandom_range(7, 6) : $urandom_range(5));
        if ($urandom_range(1)) q.kind = ($urandom_range(2) == 0) ? K_FAULT : q.kind;
        if (live_cnt_hint() > 0 && $urandom_range(2) == 0)
            pick = hint_base();
        else
            pick = $urandom_range(3) ? (32'h4000_0000 + ($urandom_range(63) << PAGE_SHIFT))
                                     : $urandom();
        q.address = pick + ($urandom_range(1) ? $urandom_range(PG - 1) : 0);
        q.length = $urandom_range(5) ? ($urandom_range(4) << PAGE_SHIFT) : $urandom();
        q.region_flags_in = 7'($urandom());
        q.shared_slot = 3'($urandom());
        q.page_count = 5'($urandom_range(3) ? $urandom_range(16, 1) : $urandom());
        q.frame_ok = ($urandom_range(4) != 0);
        if ($urandom_range(9) == 0 && q.kind == K_MAP) q.region_flags_in[FB_USER] = 1'b0;
        return q;
    endfunction

    task automatic push(t_kind k, logic [31:0] ad, logic [31:0] ln, logic [6:0] fl,
                        logic [2:0] sl, logic [4:0] pc, logic fo);
        t_req q;
        q.kind = k; q.address = ad; q.length = ln; q.region_flags_in = fl;
        q.shared_slot = sl; q.page_count = pc; q.frame_ok = fo;
        req_pending.push_back(q);
    endtask

    task automatic wait_drain();
        while (req_pending.size() != 0 || req_if.valid || rsp_expected.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FLOOR) floor_q = val; else ceil_q = val;
    endtask

    initial begin
        t_req q;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        floor_q = FLOOR_RST; ceil_q = CEIL_RST; live_cnt = 0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            tbl_base[i] = 0; tbl_limit[i] = 0; tbl_attr[i] = 0; tbl_slot[i] = 0;
        end
        for (int i = 0; i < SHARED_SLOTS; i++) obj_pages[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: every operation and the listed corner cases
        push(K_MAP, 32'h4000_0123, 32'h2000, 7'h07, 0, 0, 1);
        push(K_MAP, 32'h5000_0000, 0, 7'h07, 0, 0, 1);
        push(K_MAP, 32'h1000_0000, 32'h1000, 7'h04, 0, 0, 1);
        push(K_MAP, 32'h6000_0000, 32'h1000, 7'h03, 0, 0, 0);
        push(K_MAP, 32'h7000_0000, 32'h3000, 7'h2D, 0, 0, 1);
        push(K_MAP, 32'h8000_0000, 32'h1000, 7'h14, 0, 0, 1);
        push(K_FAULT, 32'h7000_1abc, 0, 0, 0, 0, 0);
        push(K_FAULT, 32'h7000_1abc, 0, 0, 0, 0, 1);
        push(K_FAULT, 32'h7000_1abc, 0, 0, 0, 0, 1);
        push(K_FAULT, 32'h8000_0010, 0, 0, 0, 0, 1);
        push(K_FAULT, 32'h6000_0000, 0, 0, 0, 0, 1);
        push(K_CREATE, 0, 0, 0, 0, 0, 1);
        push(K_CREATE, 0, 0, 0, 0, 17, 1);
        push(K_CREATE, 0, 0, 0, 0, 16, 0);
        push(K_CREATE, 0, 0, 0, 0, 2, 1);
        push(K_MAPSH, 32'hFFFF_F001, 0, 0, 0, 0, 1);
        push(K_MAPSH, 32'h9000_0000, 0, 0, 5, 0, 1);
        push(K_FAULT, 32'hFFFF_F800, 0, 0, 0, 0, 1);
        push(K_FAULT, 32'h0000_0800, 0, 0, 0, 0, 1);
        push(K_UNMAP, 32'h4000_0000, 32'h2000, 0, 0, 0, 1);
        push(K_UNMAP, 32'h4000_0000, 32'h2000, 0, 0, 0, 1);
        push(K_UNMAP, 32'h7000_0000, 0, 0, 0, 0, 1);
        push(K_UNMAP, 32'h7000_0000, 32'h3000, 0, 0, 0, 1);
        push(t_kind'(3'd6), 0, 0, 0, 0, 0, 1);
        push(t_kind'(3'd7), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 7, 31, 1);
        push(K_CLEAR, 0, 0, 0, 0, 0, 1);
        wait_drain();

        // Random phases at several register settings; first one without idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin write_reg(CFG_FLOOR, 32'h0); write_reg(CFG_CEIL, 32'hFFFF_FFFF); end
                2: begin write_reg(CFG_FLOOR, 32'hFFFF_FFFF); write_reg(CFG_CEIL, 32'h0); end
                3: begin write_reg(CFG_FLOOR, 32'h4001_0000); write_reg(CFG_CEIL, 32'h4003_0000); end
                4: begin write_reg(CFG_FLOOR, $urandom()); write_reg(CFG_CEIL, $urandom()); end
                5: begin write_reg(CFG_FLOOR, FLOOR_RST); write_reg(CFG_CEIL, CEIL_RST); end
                default: ;
            endcase
            idle_pct = (ph == 0) ? 0 : 33;
            for (int n = 0; n < 240; n++) begin
                q = rand_req();
                if (q.kind == K_MAP || q.kind == K_MAPSH) begin
                    recent_base.push_back(q.address & ~(PG - 1));
                    if (recent_base.size() > 16) void'(recent_base.pop_front());
                end
                if (q.kind == K_CLEAR) recent_base.delete();
                req_pending.push_back(q);
                // Hold the sender once until all results are in
                if (ph == 2 && n == 120) begin
                    while (req_pending.size() != 0 || req_if.valid) @(posedge i_clk);
                    drain_hold = 1'b1;
                    while (rsp_expected.size() != 0) @(posedge i_clk);
                    drain_hold = 1'b0;
                end
            end
            wait_drain();
        end

        if (mismatches == 0 && rsp_expected.size() == 0) begin
            $display("vm_region_fault_resolver_tb OK");
        end else begin
            $display("vm_region_fault_resolver_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("vm_region_fault_resolver_tb NOT OK");
        $finish;
    end
endmodule
